>>> sv/gbew_pkg.sv
// Shared types and constants for the gamepad binding edge watch block.
// Depends on nothing; imported by gbew_held_unit and the top level.
package gbew_pkg;

  // Default number of watched slots
  localparam int NumSlotsDef = 4;

  // Register reset values
  localparam logic [15:0] ProbePeriodRst = 16'd3000;
  localparam logic [7:0]  TrigThreshRst  = 8'd30;

  // Configuration register indexes
  localparam logic [1:0] CFG_PROBE_PERIOD = 2'd0;
  localparam logic [1:0] CFG_TRIG_THRESH  = 2'd1;

  // Request commands
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  // Trigger select codes
  localparam logic [1:0] TRIG_NONE  = 2'd0;
  localparam logic [1:0] TRIG_LEFT  = 2'd1;
  localparam logic [1:0] TRIG_RIGHT = 2'd2;

  // Stored pad word: right trigger on top, buttons at the bottom
  typedef struct packed {
    logic [7:0]  rtrig;
    logic [7:0]  ltrig;
    logic [15:0] buttons;
  } pad_t;

  // Binding handed to the evaluation unit
  typedef struct packed {
    logic [15:0] buttons;
    logic [1:0]  trig;
  } bind_t;

endpackage

>>> sv/gbew_held_unit.sv
// Shared evaluation unit: decides whether a binding is held on one pad word.
// Depends on gbew_pkg for pad_t, bind_t and the trigger codes.
module gbew_held_unit import gbew_pkg::*; (
  input  pad_t        pad_i,
  input  bind_t       bind_i,
  input  logic [7:0]  thresh_i,
  output logic        held_o
);

  logic btn_ok;
  logic trig_ok;
  logic nonempty;

  // Check buttons, selected trigger, and that the binding asks for something
  always_comb begin
    btn_ok   = (pad_i.buttons & bind_i.buttons) == bind_i.buttons;
    nonempty = (bind_i.buttons != 16'd0) || (bind_i.trig != TRIG_NONE);
    unique case (bind_i.trig)
      TRIG_LEFT:  trig_ok = pad_i.ltrig > thresh_i;
      TRIG_RIGHT: trig_ok = pad_i.rtrig > thresh_i;
      default:    trig_ok = 1'b1;
    endcase
    held_o = btn_ok && trig_ok && nonempty;
  end

endmodule

>>> sv/gamepad_binding_edge_watch_unit.sv
// Gamepad binding edge watch: per-slot pad state, reprobe timing and press queries.
// A poll sample runs the sample state, then done; a press query scans the slots in
// order, one scan state per down slot, current and previous per connected slot (pad
// through the held unit), up to the first press, then done; an invalid binding goes
// straight to done, which waits for a free output register. One request at a time:
// in_ready_o rises again once the result is in the output register. Reset clears all
// slot state and loads the register defaults. Depends on gbew_pkg and gbew_held_unit.
module gamepad_binding_edge_watch_unit import gbew_pkg::*; #(
  parameter int NUM_SLOTS = NumSlotsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // request channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [1:0]  slot_i,
  input  logic        poll_ok_i,
  input  logic [15:0] pad_buttons_i,
  input  logic [7:0]  left_trigger_i,
  input  logic [7:0]  right_trigger_i,
  input  logic [31:0] now_ms_i,
  input  logic [15:0] query_buttons_i,
  input  logic [1:0]  query_trigger_i,
  input  logic        query_valid_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        sample_taken_o,
  output logic        slot_up_o,
  output logic        pressed_o
);

  localparam int IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SAMPLE,
    ST_SCAN_CUR,
    ST_SCAN_PREV,
    ST_DONE
  } state_e;

  state_e state_q;

  // configuration registers
  logic [15:0] period_q;
  logic [7:0]  thresh_q;

  // latched request
  logic        cmd_q;
  logic [1:0]  slot_q;
  logic        ok_q;
  pad_t        pad_q;
  logic [31:0] now_q;
  bind_t       bind_q;

  // slot state
  logic [NUM_SLOTS-1:0] link_q;
  logic [NUM_SLOTS-1:0] never_q;
  pad_t                 cur_q   [NUM_SLOTS];
  pad_t                 prev_q  [NUM_SLOTS];
  logic [31:0]          stamp_q [NUM_SLOTS];

  // sequencer and result registers
  logic [IdxW-1:0] scan_idx_q;
  logic            cur_held_q;
  logic            res_taken_q;
  logic            res_up_q;
  logic            res_pressed_q;
  logic            out_valid_q;
  logic            out_taken_q;
  logic            out_up_q;
  logic            out_pressed_q;

  logic            in_fire;
  logic            slot_in_range;
  logic [IdxW-1:0] slot_idx;
  logic [IdxW-1:0] rd_idx;
  logic            rd_link;
  logic            rd_never;
  pad_t            rd_cur;
  pad_t            rd_prev;
  logic [31:0]     rd_stamp;
  logic [31:0]     elapsed;
  logic            take;
  logic            wr_en;
  pad_t            eval_pad;
  logic            held;
  logic            scan_last;
  logic            out_free;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;

  assign out_valid_o    = out_valid_q;
  assign sample_taken_o = out_taken_q;
  assign slot_up_o      = out_up_q;
  assign pressed_o      = out_pressed_q;
  assign out_free       = !out_valid_q || out_ready_i;

  // Select the slot to read: scan counter during a query, sample slot otherwise
  assign slot_in_range = 32'(slot_q) < NUM_SLOTS;
  assign slot_idx      = IdxW'(slot_q);
  assign rd_idx        = (cmd_q == CMD_QUERY) ? scan_idx_q : slot_idx;
  assign rd_link       = link_q[rd_idx];
  assign rd_never      = never_q[rd_idx];
  assign rd_cur        = cur_q[rd_idx];
  assign rd_prev       = prev_q[rd_idx];
  assign rd_stamp      = stamp_q[rd_idx];
  assign scan_last     = scan_idx_q == IdxW'(NUM_SLOTS - 1);

  // Reprobe check: take the sample for an in-range slot if up, never probed, or the period has run out
  assign elapsed = now_q - rd_stamp;
  assign take    = slot_in_range &&
                   (rd_link || rd_never || (elapsed >= {16'd0, period_q}));
  assign wr_en   = (state_q == ST_SAMPLE) && take;

  // Feed the shared unit with the current or the previous pad of the scanned slot
  assign eval_pad = (state_q == ST_SCAN_PREV) ? rd_prev : rd_cur;

  gbew_held_unit u_held (
    .pad_i    (eval_pad),
    .bind_i   (bind_q),
    .thresh_i (thresh_q),
    .held_o   (held)
  );

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= ProbePeriodRst;
      thresh_q <= TrigThreshRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_PROBE_PERIOD: period_q <= cfg_data_i;
        CFG_TRIG_THRESH:  thresh_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Capture the request on acceptance
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q  <= cmd_i;
      slot_q <= slot_i;
      ok_q   <= poll_ok_i;
      pad_q  <= '{rtrig: right_trigger_i, ltrig: left_trigger_i, buttons: pad_buttons_i};
      now_q  <= now_ms_i;
      bind_q <= '{buttons: query_buttons_i, trig: query_trigger_i};
    end
  end

  // Update slot state when a sample is taken; the new link state is the poll outcome
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q  <= '0;
      never_q <= '1;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        cur_q[i]   <= '0;
        prev_q[i]  <= '0;
        stamp_q[i] <= '0;
      end
    end else if (wr_en) begin
      link_q[slot_idx]  <= ok_q;
      never_q[slot_idx] <= 1'b0;
      if (!(rd_link && ok_q)) begin
        stamp_q[slot_idx] <= now_q;
      end
      prev_q[slot_idx] <= (ok_q && !rd_link) ? pad_q : rd_cur;
      if (ok_q) begin
        cur_q[slot_idx] <= pad_q;
      end else if (rd_link) begin
        cur_q[slot_idx] <= '0;
      end
    end
  end

  // Sequencer with result and output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      scan_idx_q    <= '0;
      cur_held_q    <= 1'b0;
      res_taken_q   <= 1'b0;
      res_up_q      <= 1'b0;
      res_pressed_q <= 1'b0;
      out_valid_q   <= 1'b0;
      out_taken_q   <= 1'b0;
      out_up_q      <= 1'b0;
      out_pressed_q <= 1'b0;
    end else begin
      if (out_ready_i && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          res_taken_q   <= 1'b0;
          res_up_q      <= 1'b0;
          res_pressed_q <= 1'b0;
          scan_idx_q    <= '0;
          if (in_fire) begin
            priority if (cmd_i == CMD_SAMPLE) begin
              state_q <= ST_SAMPLE;
            end else if (query_valid_i) begin
              state_q <= ST_SCAN_CUR;
            end else begin
              state_q <= ST_DONE;
            end
          end
        end
        ST_SAMPLE: begin
          res_taken_q <= take;
          res_up_q    <= take && ok_q;
          state_q     <= ST_DONE;
        end
        ST_SCAN_CUR: begin
          cur_held_q <= held;
          priority if (rd_link) begin
            state_q <= ST_SCAN_PREV;
          end else if (scan_last) begin
            state_q <= ST_DONE;
          end else begin
            scan_idx_q <= scan_idx_q + 1'b1;
          end
        end
        ST_SCAN_PREV: begin
          priority if (cur_held_q && !held) begin
            res_pressed_q <= 1'b1;
            state_q       <= ST_DONE;
          end else if (scan_last) begin
            state_q <= ST_DONE;
          end else begin
            scan_idx_q <= scan_idx_q + 1'b1;
            state_q    <= ST_SCAN_CUR;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            out_taken_q   <= res_taken_q;
            out_up_q      <= res_up_q;
            out_pressed_q <= res_pressed_q;
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // A connected slot has always been probed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (link_q & never_q) == '0)
    else $error("slot is up but still marked never probed");

  // A result is either a sample outcome or a query answer, never both
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(pressed_o && (sample_taken_o || slot_up_o)))
    else $error("result mixes sample and query fields");

  // A slot is reported up only for a taken sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && slot_up_o |-> sample_taken_o)
    else $error("slot up reported without a taken sample");

  // Scanning happens only for a press query
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN_CUR || state_q == ST_SCAN_PREV) |-> cmd_q == CMD_QUERY)
    else $error("slot scan running for a poll sample");

  // Slot state changes only in the sample step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(state_q) != ST_SAMPLE |-> $stable(link_q) && $stable(never_q))
    else $error("slot link state changed outside a sample");

endmodule

>>> dv/tb_gamepad_binding_edge_watch_unit.sv
// Self-checking testbench for gamepad_binding_edge_watch_unit: directed and random
// poll samples and press queries under random idling on both channels.
// Depends on gbew_pkg and the block's RTL only.
module tb_gamepad_binding_edge_watch_unit;
  import gbew_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          NUM_SLOTS    = NumSlotsDef;
  localparam int          DRAIN_CYCLES = 2 * NUM_SLOTS + 6;
  localparam int          CYCLE_LIMIT  = 400_000;
  localparam int          PHASE_ITEMS  = 110;
  // select code 3: no trigger checked, binding still counts as nonempty
  localparam logic [1:0]  TRIG_SPARE   = 2'd3;

  typedef struct packed {
    logic        cmd;
    logic [1:0]  slot;
    logic        ok;
    logic [15:0] pad_buttons;
    logic [7:0]  ltrig;
    logic [7:0]  rtrig;
    logic [31:0] now;
    logic [15:0] qbtn;
    logic [1:0]  qtrg;
    logic        qvalid;
  } watch_req_t;

  typedef struct packed {
    logic is_query;
    logic taken;
    logic up;
    logic pressed;
  } watch_result_t;

  // clock, reset and block ports
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = CFG_PROBE_PERIOD;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        cmd_i;
  logic [1:0]  slot_i;
  logic        poll_ok_i;
  logic [15:0] pad_buttons_i;
  logic [7:0]  left_trigger_i;
  logic [7:0]  right_trigger_i;
  logic [31:0] now_ms_i;
  logic [15:0] query_buttons_i;
  logic [1:0]  query_trigger_i;
  logic        query_valid_i;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        sample_taken_o;
  logic        slot_up_o;
  logic        pressed_o;

  watch_req_t  cur_req = '0;

  assign cmd_i           = cur_req.cmd;
  assign slot_i          = cur_req.slot;
  assign poll_ok_i       = cur_req.ok;
  assign pad_buttons_i   = cur_req.pad_buttons;
  assign left_trigger_i  = cur_req.ltrig;
  assign right_trigger_i = cur_req.rtrig;
  assign now_ms_i        = cur_req.now;
  assign query_buttons_i = cur_req.qbtn;
  assign query_trigger_i = cur_req.qtrg;
  assign query_valid_i   = cur_req.qvalid;

  gamepad_binding_edge_watch_unit #(
    .NUM_SLOTS(NUM_SLOTS)
  ) dut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .cmd_i,
    .slot_i,
    .poll_ok_i,
    .pad_buttons_i,
    .left_trigger_i,
    .right_trigger_i,
    .now_ms_i,
    .query_buttons_i,
    .query_trigger_i,
    .query_valid_i,
    .out_valid_o,
    .out_ready_i,
    .sample_taken_o,
    .slot_up_o,
    .pressed_o
  );

  // request and result bookkeeping
  watch_req_t    request_q[$];
  watch_result_t expected_outcome_q[$];
  int unsigned   requests_queued = 0;
  int unsigned   outcomes_checked = 0;
  int unsigned   mismatches = 0;
  int unsigned   samples_seen = 0;
  int unsigned   samples_taken = 0;
  int unsigned   queries_seen = 0;
  int unsigned   presses_seen = 0;
  int unsigned   cycle_count = 0;
  int unsigned   gap_left = 0;
  int unsigned   stall_left = 0;
  logic          quiet_stretch = 1'b0;
  watch_result_t outcome;
  watch_result_t expected;

  // predictor copy of slot state and registers
  logic [15:0] period_m;
  logic [7:0]  thresh_m;
  logic        link_m[NUM_SLOTS];
  logic        never_m[NUM_SLOTS];
  pad_t        cur_pad_m[NUM_SLOTS];
  pad_t        prev_pad_m[NUM_SLOTS];
  logic [31:0] stamp_m[NUM_SLOTS];

  // stimulus-side view of time and of the last pad stored per slot
  logic [31:0] gen_now = '0;
  pad_t        gen_pad[NUM_SLOTS];

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Count cycles, give up at the limit, and toggle stretches without idling
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
    if ($urandom_range(0, 299) == 0) begin
      quiet_stretch = !quiet_stretch;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet_stretch || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic binding_on(pad_t p, logic [15:0] btn, logic [1:0] trg);
    if (btn != '0 && (p.buttons & btn) != btn) return 1'b0;
    if (trg == TRIG_LEFT && p.ltrig <= thresh_m) return 1'b0;
    if (trg == TRIG_RIGHT && p.rtrig <= thresh_m) return 1'b0;
    return (btn != '0) || (trg != TRIG_NONE);
  endfunction

  task automatic clear_watch_state();
    period_m = ProbePeriodRst;
    thresh_m = TrigThreshRst;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      link_m[i]     = 1'b0;
      never_m[i]    = 1'b1;
      cur_pad_m[i]  = '0;
      prev_pad_m[i] = '0;
      stamp_m[i]    = '0;
      gen_pad[i]    = '0;
    end
  endtask

  // Advance the slot state by one request and work out its result
  task automatic predict_watch_outcome(input watch_req_t r, output watch_result_t res);
    logic [1:0]  s;
    logic [31:0] elapsed;
    pad_t        pad;
    res = '0;
    res.is_query = (r.cmd == CMD_QUERY);
    if (r.cmd == CMD_SAMPLE) begin
      s = r.slot;
      // drop a sample for a slot beyond the watched range
      if (32'(s) >= NUM_SLOTS) return;
      elapsed = r.now - stamp_m[s];
      if (!link_m[s] && !never_m[s] && elapsed < {16'd0, period_m}) return;
      if (!link_m[s]) begin
        stamp_m[s] = r.now;
        never_m[s] = 1'b0;
      end
      prev_pad_m[s] = cur_pad_m[s];
      pad = '{rtrig: r.rtrig, ltrig: r.ltrig, buttons: r.pad_buttons};
      if (r.ok) begin
        cur_pad_m[s] = pad;
        if (!link_m[s]) begin
          link_m[s] = 1'b1;
          prev_pad_m[s] = pad;
        end
      end else if (link_m[s]) begin
        link_m[s] = 1'b0;
        stamp_m[s] = r.now;
        cur_pad_m[s] = '0;
      end
      res.taken = 1'b1;
      res.up = link_m[s];
    end else if (r.qvalid) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (link_m[i] && binding_on(cur_pad_m[i], r.qbtn, r.qtrg) &&
            !binding_on(prev_pad_m[i], r.qbtn, r.qtrg)) begin
          res.pressed = 1'b1;
        end
      end
    end
  endtask

  // Driver: predict on acceptance, then present the next request after a gap
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_watch_outcome(cur_req, outcome);
        expected_outcome_q.push_back(outcome);
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (request_q.size() > 0) begin
          cur_req <= request_q.pop_front();
          in_valid_i <= 1'b1;
          gap_left = pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result against the oldest expectation, stall at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_outcome_q.size() == 0) begin
          $error("result arrived with no request outstanding");
          mismatches++;
        end else begin
          expected = expected_outcome_q.pop_front();
          if (sample_taken_o !== expected.taken) begin
            $error("sample_taken: expected %0b, got %0b", expected.taken, sample_taken_o);
            mismatches++;
          end
          if (slot_up_o !== expected.up) begin
            $error("slot_up: expected %0b, got %0b", expected.up, slot_up_o);
            mismatches++;
          end
          if (pressed_o !== expected.pressed) begin
            $error("pressed: expected %0b, got %0b", expected.pressed, pressed_o);
            mismatches++;
          end
          if (expected.is_query) begin
            queries_seen++;
            presses_seen += expected.pressed;
          end else begin
            samples_seen++;
            samples_taken += expected.taken;
          end
          outcomes_checked++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        stall_left = pick_gap();
        out_ready_i <= (stall_left == 0);
      end
    end
  end

  task automatic queue_sample(input logic [1:0] s, input logic ok, input pad_t p,
                              input logic [31:0] now);
    watch_req_t r;
    r = watch_req_t'({$urandom, $urandom, $urandom});
    r.cmd         = CMD_SAMPLE;
    r.slot        = s;
    r.ok          = ok;
    r.pad_buttons = p.buttons;
    r.ltrig       = p.ltrig;
    r.rtrig       = p.rtrig;
    r.now         = now;
    request_q.push_back(r);
    requests_queued++;
    if (ok) gen_pad[s] = p;
  endtask

  task automatic queue_query(input logic [15:0] btn, input logic [1:0] trg, input logic ok);
    watch_req_t r;
    r = watch_req_t'({$urandom, $urandom, $urandom});
    r.cmd    = CMD_QUERY;
    r.qbtn   = btn;
    r.qtrg   = trg;
    r.qvalid = ok;
    request_q.push_back(r);
    requests_queued++;
  endtask

  // Mostly small steps in time, some past a reprobe period, rare wild jumps
  function automatic logic [31:0] time_step();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return $urandom_range(0, 20);
    if (r < 88) return $urandom_range(0, 4000);
    if (r < 98) return $urandom_range(0, 70000);
    return $urandom;
  endfunction

  function automatic logic [7:0] near_thresh(logic [7:0] thr);
    return 8'(int'(thr) + int'($urandom_range(0, 2)) - 1);
  endfunction

  // Derive a new pad from the last one, with triggers often close to the threshold
  function automatic pad_t vary_pad(pad_t base, logic [7:0] thr);
    pad_t p;
    if ($urandom_range(0, 99) < 20) return pad_t'($urandom);
    p = base;
    p.buttons = p.buttons ^ (16'd1 << $urandom_range(0, 15));
    if ($urandom_range(0, 1) == 1) p.buttons = p.buttons ^ 16'($urandom & $urandom);
    case ($urandom_range(0, 3))
      0: p.ltrig = near_thresh(thr);
      1: p.rtrig = near_thresh(thr);
      2: p.ltrig = 8'($urandom);
      default: p.rtrig = 8'($urandom);
    endcase
    return p;
  endfunction

  task automatic queue_random_traffic(input int unsigned n, input logic [7:0] thr);
    int unsigned made;
    int unsigned pick;
    int unsigned k;
    logic [1:0]  s;
    logic [1:0]  trg;
    logic [15:0] qb;
    pad_t        a;
    pad_t        b;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(0, 99);
      s = 2'($urandom_range(0, NUM_SLOTS - 1));
      if (pick < 45) begin
        gen_now = gen_now + time_step();
        queue_sample(s, $urandom_range(0, 99) < 85, vary_pad(gen_pad[s], thr), gen_now);
        made++;
      end else if (pick < 65) begin
        // press sequence: a pad without the binding, then one with it, then the query
        k = $urandom_range(0, 15);
        trg = 2'($urandom_range(0, 3));
        a = vary_pad(gen_pad[s], thr);
        a.buttons[k] = 1'b0;
        a.ltrig = 8'($urandom_range(0, int'(thr)));
        a.rtrig = 8'($urandom_range(0, int'(thr)));
        b = a;
        b.buttons = a.buttons | (16'd1 << k) | 16'($urandom & $urandom);
        b.ltrig = (thr == 8'd255) ? 8'd255 : 8'($urandom_range(int'(thr) + 1, 255));
        b.rtrig = (thr == 8'd255) ? 8'd255 : 8'($urandom_range(int'(thr) + 1, 255));
        qb = (b.buttons & 16'($urandom)) | (16'd1 << k);
        if (trg != TRIG_SPARE && $urandom_range(0, 3) == 0) qb = '0;
        gen_now = gen_now + time_step();
        queue_sample(s, 1'b1, a, gen_now);
        gen_now = gen_now + 32'($urandom_range(0, 20));
        queue_sample(s, 1'b1, b, gen_now);
        queue_query(qb, trg, 1'b1);
        made += 3;
      end else begin
        qb = gen_pad[s].buttons & 16'($urandom);
        if (pick < 72) qb = '0;
        else if (pick < 78) qb = 16'($urandom);
        queue_query(qb, 2'($urandom_range(0, 3)), $urandom_range(0, 9) != 0);
        made++;
      end
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_PROBE_PERIOD: period_m = val;
      CFG_TRIG_THRESH:  thresh_m = val[7:0];
      default: ;
    endcase
  endtask

  // Hold until every queued request has been answered, then let the block settle
  task automatic wait_drained();
    while (outcomes_checked != requests_queued) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  logic [15:0] period_set[5];
  logic [7:0]  thresh_set[5];

  initial begin
    clear_watch_state();
    period_set = '{16'd3000, 16'd0, 16'd65535, 16'd100, 16'($urandom)};
    thresh_set = '{8'd30, 8'd0, 8'd255, 8'd128, 8'($urandom)};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: register defaults after reset, reprobe timing, wrap and threshold
    queue_query(16'hFFFF, TRIG_LEFT, 1'b1);
    queue_sample(2'd0, 1'b1, pad_t'('0), 32'd0);
    queue_sample(2'd0, 1'b1, pad_t'({8'hFF, 8'hFF, 16'hFFFF}), 32'd5);
    queue_query(16'hFFFF, TRIG_LEFT, 1'b1);
    queue_query(16'hFFFF, TRIG_LEFT, 1'b0);
    queue_query(16'h0000, TRIG_NONE, 1'b1);
    queue_query(16'h0000, TRIG_SPARE, 1'b1);
    queue_query(16'h0001, TRIG_SPARE, 1'b1);
    queue_query(16'h0000, TRIG_RIGHT, 1'b1);
    queue_sample(2'd1, 1'b0, pad_t'({8'hFF, 8'hFF, 16'hFFFF}), 32'd10);
    queue_sample(2'd1, 1'b1, pad_t'('0), 32'd100);
    queue_sample(2'd0, 1'b0, pad_t'('0), 32'd3005);
    queue_sample(2'd0, 1'b1, pad_t'({8'hFF, 8'hFF, 16'hFFFF}), 32'd3006);
    queue_sample(2'd1, 1'b1, pad_t'({8'd31, 8'd30, 16'h00A5}), 32'd3010);
    queue_query(16'h0000, TRIG_LEFT, 1'b1);
    queue_query(16'h0000, TRIG_RIGHT, 1'b1);
    queue_sample(2'd1, 1'b1, pad_t'({8'd0, 8'd31, 16'h00A5}), 32'd3011);
    queue_query(16'h0000, TRIG_LEFT, 1'b1);
    queue_query(16'h00A5, TRIG_NONE, 1'b1);
    queue_sample(2'd2, 1'b0, pad_t'('0), 32'hFFFF_FF00);
    queue_sample(2'd2, 1'b1, pad_t'('0), 32'hFFFF_FFFF);
    queue_sample(2'd2, 1'b1, pad_t'({8'hFF, 8'h00, 16'h8000}), 32'h0000_0B00);
    queue_sample(2'd3, 1'b1, pad_t'('0), 32'h0000_0B00);
    queue_query(16'h8000, TRIG_NONE, 1'b1);
    gen_now = 32'h0000_0B00;
    wait_drained();

    // Random phases, each under its own register setting
    for (int p = 0; p < 5; p++) begin
      write_reg(CFG_PROBE_PERIOD, period_set[p]);
      write_reg(CFG_TRIG_THRESH, {8'd0, thresh_set[p]});
      // start one phase close to the wrap of the millisecond counter
      if (p == 3) gen_now = 32'hFFFF_0000;
      queue_random_traffic(PHASE_ITEMS / 2, thresh_set[p]);
      wait_drained();
      queue_random_traffic(PHASE_ITEMS - PHASE_ITEMS / 2, thresh_set[p]);
      wait_drained();
    end

    $display("Checked %0d poll samples (%0d taken) and %0d press queries (%0d pressed)",
             samples_seen, samples_taken, queries_seen, presses_seen);
    $display("under reset defaults and 5 register settings; %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
